// File: hdl/wnp_pkg.sv
// Shared types and constants for the winding-number point-in-polygon block.
package wnp_pkg;

    // Width of the running winding count and its saturation limits.
    localparam int COUNT_BITS = 16;
    localparam logic signed [COUNT_BITS-1:0] COUNT_MAX = 16'sh7FFF;
    localparam logic signed [COUNT_BITS-1:0] COUNT_MIN = 16'sh8000;

    // Number of edge words buffered between the front and back parts.
    localparam int QUEUE_DEPTH = 4;

    // Configuration register indexes.
    typedef enum logic [0:0] {
        REG_QUERY_X = 1'b0,
        REG_QUERY_Y = 1'b1
    } cfg_reg_e_t;

    // Classification of one vertex, carried with its edge terms.
    typedef struct packed {
        logic first;   // vertex opens a polygon, no edge is tested
        logic last;    // vertex closes the polygon, a result is due
        logic up;      // edge crosses the query line going up
        logic down;    // edge crosses the query line going down
    } edge_cls_t;

endpackage

// File: hdl/wnp_queue.sv
// Small first-in first-out buffer of edge words between the front and back parts.
module wnp_queue
    import wnp_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] din,
    output logic             full,
    input  logic             pop,
    output logic             not_empty,
    output logic [WIDTH-1:0] dout
);

    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);
    localparam logic [PTR_BITS-1:0] LAST_PTR = PTR_BITS'(DEPTH - 1);
    localparam logic [CNT_BITS-1:0] FULL_CNT = CNT_BITS'(DEPTH);

    logic [WIDTH-1:0]    storage_reg [DEPTH];
    logic [PTR_BITS-1:0] head_reg, head_next;
    logic [PTR_BITS-1:0] tail_reg, tail_next;
    logic [CNT_BITS-1:0] fill_reg, fill_next;

    assign full      = (fill_reg == FULL_CNT);
    assign not_empty = (fill_reg != '0);
    assign dout      = storage_reg[head_reg];

    // Pointer and fill count updates, wrapping at the depth.
    always_comb
    begin
        head_next = head_reg;
        tail_next = tail_reg;
        fill_next = fill_reg;
        if (push)
        begin
            tail_next = (tail_reg == LAST_PTR) ? '0 : tail_reg + 1'b1;
        end
        if (pop)
        begin
            head_next = (head_reg == LAST_PTR) ? '0 : head_reg + 1'b1;
        end
        if (push && !pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            tail_reg <= '0;
            fill_reg <= '0;
        end
        else
        begin
            head_reg <= head_next;
            tail_reg <= tail_next;
            fill_reg <= fill_next;
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            storage_reg[tail_reg] <= din;
        end
    end

endmodule

// File: hdl/wnp_front.sv
// Front part: query registers, previous vertex, crossing classification and edge terms.
module wnp_front
    import wnp_pkg::*;
#(
    parameter int COORD_BITS = 24
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [0:0]                   cfg_index,
    input  logic [COORD_BITS-1:0]        cfg_data,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic signed [COORD_BITS-1:0] vertex_x,
    input  logic signed [COORD_BITS-1:0] vertex_y,
    input  logic                         first,
    input  logic                         last,
    input  logic                         q_full,
    output logic                         q_push,
    output edge_cls_t                    cls,
    output logic signed [COORD_BITS:0]   dx,
    output logic signed [COORD_BITS:0]   dyp,
    output logic signed [COORD_BITS:0]   dxp,
    output logic signed [COORD_BITS:0]   dy
);

    localparam int MSB = COORD_BITS - 1;

    logic signed [COORD_BITS-1:0] query_x_reg;
    logic signed [COORD_BITS-1:0] query_y_reg;
    logic signed [COORD_BITS-1:0] prev_x_reg;
    logic signed [COORD_BITS-1:0] prev_y_reg;
    logic                         accept;

    // A word is taken whenever the queue has room.
    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;
    assign q_push   = accept;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            query_x_reg <= '0;
            query_y_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_e_t'(cfg_index))
                REG_QUERY_X: query_x_reg <= cfg_data;
                REG_QUERY_Y: query_y_reg <= cfg_data;
                default:     query_x_reg <= query_x_reg;
            endcase
        end
    end

    // Previous vertex, kept across polygons.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_x_reg <= '0;
            prev_y_reg <= '0;
        end
        else if (accept)
        begin
            prev_x_reg <= vertex_x;
            prev_y_reg <= vertex_y;
        end
    end

    // Classify the edge from the previous vertex against the query line.
    always_comb
    begin
        cls.first = first;
        cls.last  = last;
        cls.up    = !first && (prev_y_reg <= query_y_reg) && (vertex_y > query_y_reg);
        cls.down  = !first && (prev_y_reg > query_y_reg) && (vertex_y <= query_y_reg);
    end

    // Differences for the side test, one bit wider than the coordinates.
    assign dx  = $signed({vertex_x[MSB], vertex_x}) - $signed({prev_x_reg[MSB], prev_x_reg});
    assign dyp = $signed({query_y_reg[MSB], query_y_reg})
               - $signed({prev_y_reg[MSB], prev_y_reg});
    assign dxp = $signed({query_x_reg[MSB], query_x_reg})
               - $signed({prev_x_reg[MSB], prev_x_reg});
    assign dy  = $signed({vertex_y[MSB], vertex_y}) - $signed({prev_y_reg[MSB], prev_y_reg});

endmodule

// File: hdl/wnp_back.sv
// Back part: side-test products, winding count update and the result register.
module wnp_back
    import wnp_pkg::*;
#(
    parameter int COORD_BITS = 24
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           q_not_empty,
    output logic                           q_pop,
    input  edge_cls_t                      cls,
    input  logic signed [COORD_BITS:0]     dx,
    input  logic signed [COORD_BITS:0]     dyp,
    input  logic signed [COORD_BITS:0]     dxp,
    input  logic signed [COORD_BITS:0]     dy,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic signed [COUNT_BITS-1:0]   winding,
    output logic                           inside_res,
    output logic                           saturated
);

    localparam int PROD_BITS = 2 * (COORD_BITS + 1);
    localparam int SIDE_BITS = PROD_BITS + 1;

    logic                         advance;
    logic                         s1_valid_reg;
    edge_cls_t                    s1_cls_reg;
    logic signed [PROD_BITS-1:0]  s1_p1_reg;
    logic signed [PROD_BITS-1:0]  s1_p2_reg;
    logic signed [SIDE_BITS-1:0]  side;
    logic                         side_pos;
    logic                         side_neg;
    logic signed [COUNT_BITS-1:0] count_reg, count_next;
    logic                         sat_reg, sat_next;
    logic                         out_valid_reg;
    logic signed [COUNT_BITS-1:0] winding_reg;
    logic                         inside_reg;
    logic                         saturated_reg;

    // The pipeline moves unless a finished result is held by the receiver.
    assign advance = !(out_valid_reg && out_stall);
    assign q_pop   = q_not_empty && advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg <= q_not_empty;
        end
    end

    // Stage one: the two cross-product terms.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_cls_reg <= cls;
            s1_p1_reg  <= dx * dyp;
            s1_p2_reg  <= dxp * dy;
        end
    end

    // Stage two: sign of the side test and the saturating count step.
    assign side     = SIDE_BITS'(s1_p1_reg) - SIDE_BITS'(s1_p2_reg);
    assign side_neg = side[SIDE_BITS-1];
    assign side_pos = !side_neg && (side != '0);

    always_comb
    begin
        count_next = count_reg;
        sat_next   = sat_reg;
        if (s1_cls_reg.first)
        begin
            count_next = '0;
            sat_next   = 1'b0;
        end
        else if (s1_cls_reg.up && side_pos)
        begin
            if (count_reg != COUNT_MAX)
            begin
                count_next = count_reg + 16'sd1;
            end
            else
            begin
                sat_next = 1'b1;
            end
        end
        else if (s1_cls_reg.down && side_neg)
        begin
            if (count_reg != COUNT_MIN)
            begin
                count_next = count_reg - 16'sd1;
            end
            else
            begin
                sat_next = 1'b1;
            end
        end
    end

    // Count state clears after a closing vertex.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            sat_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= s1_valid_reg && s1_cls_reg.last;
            if (s1_valid_reg)
            begin
                if (s1_cls_reg.last)
                begin
                    count_reg <= '0;
                    sat_reg   <= 1'b0;
                end
                else
                begin
                    count_reg <= count_next;
                    sat_reg   <= sat_next;
                end
            end
        end
    end

    // Result word register.
    always_ff @(posedge clk)
    begin
        if (advance && s1_valid_reg && s1_cls_reg.last)
        begin
            winding_reg   <= count_next;
            inside_reg    <= (count_next != '0);
            saturated_reg <= sat_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign winding    = winding_reg;
    assign inside_res = inside_reg;
    assign saturated  = saturated_reg;

endmodule

// File: hdl/winding_number_point_in_polygon.sv
// Top level of the winding-number point-in-polygon block.
//
//   channel  direction  handshake             word
//   vertex   in         in_valid / in_stall   vertex_x, vertex_y, first, last
//   result   out        out_valid / out_stall winding, inside_res, saturated
//   config   in         cfg_we                cfg_index, cfg_data
//
// One vertex word is taken every cycle while the four-entry edge queue has room.
// A result word follows the edge that takes its closing vertex through the queue
// storage and the product stage, then the count stage registers it. The sustained
// rate is one vertex per cycle while no result is held by out_stall, set by the
// single count update per cycle in the back part. Reset clears the query point,
// the previous vertex and the count. A stalled result halts only the back part;
// the front keeps taking vertices until the queue fills.
module winding_number_point_in_polygon
    import wnp_pkg::*;
#(
    parameter int COORD_BITS = 24
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [0:0]                     cfg_index,
    input  logic [COORD_BITS-1:0]          cfg_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic signed [COORD_BITS-1:0]   vertex_x,
    input  logic signed [COORD_BITS-1:0]   vertex_y,
    input  logic                           first,
    input  logic                           last,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic signed [COUNT_BITS-1:0]   winding,
    output logic                           inside_res,
    output logic                           saturated
);

    localparam int DW = COORD_BITS + 1;
    localparam int CW = $bits(edge_cls_t);
    localparam int QW = CW + 4 * DW;

    edge_cls_t              f_cls;
    edge_cls_t              b_cls;
    logic signed [DW-1:0]   f_dx, f_dyp, f_dxp, f_dy;
    logic [QW-1:0]          q_din;
    logic [QW-1:0]          q_dout;
    logic                   q_push;
    logic                   q_pop;
    logic                   q_full;
    logic                   q_not_empty;

    wnp_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .vertex_x  (vertex_x),
        .vertex_y  (vertex_y),
        .first     (first),
        .last      (last),
        .q_full    (q_full),
        .q_push    (q_push),
        .cls       (f_cls),
        .dx        (f_dx),
        .dyp       (f_dyp),
        .dxp       (f_dxp),
        .dy        (f_dy)
    );

    // Pack the classified edge into one queue word.
    assign q_din = {f_cls, f_dx, f_dyp, f_dxp, f_dy};

    wnp_queue #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .din       (q_din),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .dout      (q_dout)
    );

    assign b_cls = edge_cls_t'(q_dout[QW-1 -: CW]);

    wnp_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .q_pop       (q_pop),
        .cls         (b_cls),
        .dx          ($signed(q_dout[4*DW-1 -: DW])),
        .dyp         ($signed(q_dout[3*DW-1 -: DW])),
        .dxp         ($signed(q_dout[2*DW-1 -: DW])),
        .dy          ($signed(q_dout[DW-1 -: DW])),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .winding     (winding),
        .inside_res  (inside_res),
        .saturated   (saturated)
    );

endmodule
